>>> design/hsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV histogram package
// Shared widths, constants and codes for the HSV histogram accumulator.
// ----------------------------------------------------------------------------
package hsv_pkg;
   localparam int COUNT_BITS = 20;
   localparam int HUE_BINS   = 180;
   localparam int SV_BINS    = 256;
   localparam int ADDR_BITS  = 8;

   typedef enum logic [1:0] {
      FUNC_ACCUM = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CH_HUE  = 2'd0,
      CH_SAT  = 2'd1,
      CH_VAL  = 2'd2,
      CH_NONE = 2'd3
   } chan_type;
endpackage

>>> design/hsv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module hsv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/hsv_histogram_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV histogram accumulator
// Converts BGR pixels to HSV and counts hue, saturation and value bins.
// ----------------------------------------------------------------------------
// A read request passes through the read and response states; the strobe is registered in the latter.
// An accumulate request keeps busy high through two eight-step bit-serial divides, a bin
// read and a write-back; a read request keeps it high through the bin read and the response.
// A clear request sweeps 256 addresses, one per cycle, with busy high throughout.
// Reset starts the same sweep; busy stays high until the sweep ends.
// The result strobe cannot be stalled by the receiver.
module hsv_histogram_accumulator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_func,
   input  logic [7:0]                    req_blue,
   input  logic [7:0]                    req_green,
   input  logic [7:0]                    req_red,
   input  logic [1:0]                    req_channel,
   input  logic [7:0]                    req_bin_index,
   output logic                          rsp_valid,
   output logic [hsv_pkg::COUNT_BITS-1:0] rsp_count
);
   import hsv_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_DIVS, ST_DIVH, ST_READ, ST_WRITE, ST_RESP
   } state_type;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   state_type state_ff;
   logic [ADDR_BITS-1:0] sweep_ff;
   logic [3:0]           step_ff;
   logic [1:0]           func_ff;
   logic [1:0]           chan_ff;
   logic [7:0]           idx_ff;
   logic [7:0]           mx_ff;
   logic [7:0]           d_ff;
   logic [10:0]          hnum_ff;   // hue numerator in units of 60/d degrees
   // Division remainder and quotient registers shared by both divides.
   logic [17:0]          rem_ff;
   logic [17:0]          den_ff;
   logic [7:0]           quo_ff;
   logic [7:0]           s_ff;
   logic [7:0]           h_ff;
   logic                 skip_ff;
   logic                 valid_ff;
   logic [COUNT_BITS-1:0] count_ff;

   logic [7:0]  mx_in, mn_in, d_in;
   logic [10:0] hnum_in;
   logic [17:0] rem_in;
   logic [7:0]  quo_in;
   logic [18:0] trial;

   logic                 wr_en;
   logic [7:0]           wr_h, wr_s, wr_v;
   logic [COUNT_BITS-1:0] wd_h, wd_s, wd_v;
   logic [7:0]           ra_h, ra_s, ra_v;
   logic [COUNT_BITS-1:0] rd_h, rd_s, rd_v;
   logic                 clr;

   // Pixel max, min and hue numerator from the request fields.
   always_comb begin
      mx_in = req_blue;
      mn_in = req_blue;
      if (req_green > mx_in) mx_in = req_green;
      if (req_red > mx_in) mx_in = req_red;
      if (req_green < mn_in) mn_in = req_green;
      if (req_red < mn_in) mn_in = req_red;
      d_in = mx_in - mn_in;
      if (mx_in == req_red) begin
         hnum_in = (req_green >= req_blue) ? {3'b000, req_green - req_blue}
            : 11'(({3'b000, d_in} * 11'd6) - {3'b000, req_blue - req_green});
      end else if (mx_in == req_green) begin
         hnum_in = 11'({2'b00, d_in, 1'b0} + {3'b000, req_blue} - {3'b000, req_red});
      end else begin
         hnum_in = 11'({1'b0, d_in, 2'b00} + {3'b000, req_red} - {3'b000, req_green});
      end
   end

   // One restoring division step: trial subtract of the shifted divisor.
   always_comb begin
      trial  = {1'b0, rem_ff} - {1'b0, den_ff >> (step_ff + 4'd1)};
      rem_in = rem_ff;
      quo_in = {quo_ff[6:0], 1'b0};
      if (!trial[18]) begin
         rem_in = trial[17:0];
         quo_in[0] = 1'b1;
      end
   end

   // Memory addressing: sweep while clearing, the requested index for a read, otherwise the current bins.
   assign clr   = (state_ff == ST_CLEAR);
   assign wr_en = clr || (state_ff == ST_WRITE && !skip_ff);
   assign wr_h  = clr ? sweep_ff : h_ff;
   assign wr_s  = clr ? sweep_ff : s_ff;
   assign wr_v  = clr ? sweep_ff : mx_ff;
   assign wd_h  = clr ? '0 : (rd_h == COUNT_MAX ? rd_h : rd_h + 1'b1);
   assign wd_s  = clr ? '0 : (rd_s == COUNT_MAX ? rd_s : rd_s + 1'b1);
   assign wd_v  = clr ? '0 : (rd_v == COUNT_MAX ? rd_v : rd_v + 1'b1);
   assign ra_h  = (func_ff == FUNC_READ) ? idx_ff : h_ff;
   assign ra_s  = (func_ff == FUNC_READ) ? idx_ff : s_ff;
   assign ra_v  = (func_ff == FUNC_READ) ? idx_ff : mx_ff;

   hsv_ram #(.WIDTH(COUNT_BITS), .DEPTH(SV_BINS)) u_hue (
      .clock(clock), .wr_en(wr_en && (clr || h_ff < 8'(HUE_BINS))),
      .wr_addr(wr_h), .wr_data(wd_h), .rd_addr(ra_h), .rd_data(rd_h));
   hsv_ram #(.WIDTH(COUNT_BITS), .DEPTH(SV_BINS)) u_sat (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_s), .wr_data(wd_s),
      .rd_addr(ra_s), .rd_data(rd_s));
   hsv_ram #(.WIDTH(COUNT_BITS), .DEPTH(SV_BINS)) u_val (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_v), .wr_data(wd_v),
      .rd_addr(ra_v), .rd_data(rd_v));

   // Sequencer: state and registered outputs.
   always_ff @(posedge clock) begin
      valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  func_ff  <= req_func;
                  chan_ff  <= req_channel;
                  idx_ff   <= req_bin_index;
                  mx_ff    <= mx_in;
                  d_ff     <= d_in;
                  hnum_ff  <= hnum_in;
                  skip_ff  <= (mx_in == 8'd0);
                  sweep_ff <= '0;
                  step_ff  <= '0;
                  quo_ff   <= '0;
                  // S = (510*d + mx) / (2*mx)
                  rem_ff   <= 18'(({10'd0, d_in} * 18'd510) + {10'd0, mx_in});
                  den_ff   <= {mx_in, 10'd0} >> 1;
                  case (req_func)
                     FUNC_ACCUM: state_ff <= ST_DIVS;
                     FUNC_READ:  state_ff <= ST_READ;
                     FUNC_CLEAR: state_ff <= ST_CLEAR;
                     default:    state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == 8'd255) state_ff <= ST_IDLE;
            end
            ST_DIVS: begin
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd7) begin
                  s_ff    <= quo_in;
                  step_ff <= '0;
                  quo_ff  <= '0;
                  // H = (60*num + d) / (2*d)
                  rem_ff  <= 18'(({7'd0, hnum_ff} * 18'd60) + {10'd0, d_ff});
                  den_ff  <= {1'b0, d_ff, 9'd0};
                  state_ff <= ST_DIVH;
               end
            end
            ST_DIVH: begin
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd7) begin
                  if (d_ff == 8'd0) h_ff <= '0;
                  else if (quo_in >= 8'(HUE_BINS)) h_ff <= quo_in - 8'(HUE_BINS);
                  else h_ff <= quo_in;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= (func_ff == FUNC_READ) ? ST_RESP : ST_WRITE;
            end
            ST_WRITE: begin
               state_ff <= ST_IDLE;
            end
            ST_RESP: begin
               valid_ff <= 1'b1;
               case (chan_ff)
                  CH_HUE:  count_ff <= (idx_ff < 8'(HUE_BINS)) ? rd_h : '0;
                  CH_SAT:  count_ff <= rd_s;
                  CH_VAL:  count_ff <= rd_v;
                  default: count_ff <= '0;
               endcase
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_count = count_ff;

   // A response only follows the response state.
   a_resp_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_RESP) else $error("stray response");
   // Writes only occur while clearing or writing back.
   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_WRITE))
      else $error("unexpected write");
   // Each divide runs for eight steps and no more.
   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVS || state_ff == ST_DIVH) |-> step_ff < 4'd8)
      else $error("divider overrun");
   // Hue bin after wrap is within range.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> h_ff < 8'(HUE_BINS)) else $error("hue out of range");
endmodule
